// File: rtl/m68kl0_pkg.sv
// Shared types, codes and helpers for the 68030 line-0 opcode decoder.
// No dependencies; used by m68kl0_decode and m68k_line0_instruction_decoder.
package m68kl0_pkg;

	// Operation kinds
	localparam logic [4:0] OP_INVALID  = 5'd0;
	localparam logic [4:0] OP_ORI      = 5'd1;
	localparam logic [4:0] OP_ANDI     = 5'd2;
	localparam logic [4:0] OP_SUBI     = 5'd3;
	localparam logic [4:0] OP_ADDI     = 5'd4;
	localparam logic [4:0] OP_EORI     = 5'd5;
	localparam logic [4:0] OP_CMPI     = 5'd6;
	localparam logic [4:0] OP_MOVES    = 5'd7;
	localparam logic [4:0] OP_ORI_CCR  = 5'd8;
	localparam logic [4:0] OP_ANDI_CCR = 5'd9;
	localparam logic [4:0] OP_EORI_CCR = 5'd10;
	localparam logic [4:0] OP_ORI_SR   = 5'd11;
	localparam logic [4:0] OP_ANDI_SR  = 5'd12;
	localparam logic [4:0] OP_EORI_SR  = 5'd13;
	localparam logic [4:0] OP_BTST     = 5'd14;
	localparam logic [4:0] OP_BCHG     = 5'd15;
	localparam logic [4:0] OP_BCLR     = 5'd16;
	localparam logic [4:0] OP_BSET     = 5'd17;
	localparam logic [4:0] OP_MOVEP    = 5'd18;

	// Effective address classes
	localparam logic [3:0] EA_NONE = 4'd0;
	localparam logic [3:0] EA_DN   = 4'd1;
	localparam logic [3:0] EA_ABSW = 4'd8;

	// Field codes
	localparam logic [2:0] MODE_AN     = 3'd1;
	localparam logic [2:0] MODE_EXT    = 3'd7;
	localparam logic [2:0] REG_IMM     = 3'd4;
	localparam logic [2:0] ROW_OR      = 3'd0;
	localparam logic [2:0] ROW_AND     = 3'd1;
	localparam logic [2:0] ROW_STATIC  = 3'd4;
	localparam logic [2:0] ROW_EOR     = 3'd5;
	localparam logic [2:0] ROW_MOVES   = 3'd7;
	localparam logic [1:0] SZF_BYTE    = 2'd0;
	localparam logic [1:0] SZF_WORD    = 2'd1;
	localparam logic [1:0] SZF_LONG    = 2'd2;
	localparam logic [1:0] SZF_EXTRA   = 2'd3;
	localparam logic [2:0] SIZE_NONE   = 3'd0;
	localparam logic [2:0] SIZE_BYTE   = 3'd1;
	localparam logic [2:0] SIZE_WORD   = 3'd2;
	localparam logic [2:0] SIZE_LONG   = 3'd4;

	// Decoded result
	typedef struct packed {
		logic [4:0] op_kind;
		logic [2:0] data_reg;
		logic [2:0] addr_reg;
		logic       to_memory;
		logic [2:0] size_bytes;
		logic       bit_number_in_reg;
		logic [3:0] ea_class;
		logic [2:0] ea_reg;
		logic       privileged;
	} dec_result_t;

	// EA class from mode and register; EA_NONE marks an illegal mode 7 form
	function automatic logic [3:0] ea_class_of(input logic [2:0] mode, input logic [2:0] rg);
		logic [3:0] c;
		if (mode != MODE_EXT) begin
			c = {1'b0, mode} + 4'd1;
		end else if (rg <= REG_IMM) begin
			c = EA_ABSW + {1'b0, rg};
		end else begin
			c = EA_NONE;
		end
		return c;
	endfunction

	// Immediate op kind by row (static bit row never reaches here)
	function automatic logic [4:0] imm_kind_of_row(input logic [2:0] row);
		logic [4:0] k;
		unique case (row)
			3'd0:    k = OP_ORI;
			3'd1:    k = OP_ANDI;
			3'd2:    k = OP_SUBI;
			3'd3:    k = OP_ADDI;
			3'd5:    k = OP_EORI;
			3'd6:    k = OP_CMPI;
			3'd7:    k = OP_MOVES;
			default: k = OP_INVALID;
		endcase
		return k;
	endfunction

	// Bit operation kind from a two-bit selector
	function automatic logic [4:0] bit_kind_of(input logic [1:0] sel);
		logic [4:0] k;
		unique case (sel)
			2'd0: k = OP_BTST;
			2'd1: k = OP_BCHG;
			2'd2: k = OP_BCLR;
			2'd3: k = OP_BSET;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/m68kl0_decode.sv
// Combinational line-0 opcode decode: one 16-bit word to one decoded result.
// Depends on m68kl0_pkg.
module m68kl0_decode (
	input  logic [15:0]              word,
	output m68kl0_pkg::dec_result_t  res
);

	logic [2:0] row, opmode, mode, rg;
	logic [1:0] szf;

	assign row    = word[11:9];
	assign opmode = word[8:6];
	assign szf    = word[7:6];
	assign mode   = word[5:3];
	assign rg     = word[2:0];

	always_comb begin
		m68kl0_pkg::dec_result_t r;
		logic       uses_ea;
		logic [3:0] eac;
		r       = '0;
		uses_ea = 1'b0;
		eac     = m68kl0_pkg::ea_class_of(mode, rg);

		if (word[15:12] == 4'd0) begin
			priority if (word[8]) begin
				if (mode == m68kl0_pkg::MODE_AN) begin
					// MOVEP
					r.op_kind    = m68kl0_pkg::OP_MOVEP;
					r.data_reg   = row;
					r.addr_reg   = rg;
					r.to_memory  = opmode[2] & opmode[1];
					r.size_bytes = opmode[0] ? m68kl0_pkg::SIZE_LONG
						: m68kl0_pkg::SIZE_WORD;
				end else begin
					// dynamic bit op, bit number in Dn
					r.op_kind           = m68kl0_pkg::bit_kind_of(opmode[1:0]);
					r.data_reg          = row;
					r.bit_number_in_reg = 1'b1;
					uses_ea             = 1'b1;
				end
			end else if (row == m68kl0_pkg::ROW_STATIC) begin
				// static bit op
				r.op_kind = m68kl0_pkg::bit_kind_of(szf);
				uses_ea   = 1'b1;
			end else if (mode == m68kl0_pkg::MODE_EXT && rg == m68kl0_pkg::REG_IMM) begin
				// CCR / SR forms
				if (szf == m68kl0_pkg::SZF_BYTE) begin
					unique case (row)
						m68kl0_pkg::ROW_OR:  r.op_kind = m68kl0_pkg::OP_ORI_CCR;
						m68kl0_pkg::ROW_AND: r.op_kind = m68kl0_pkg::OP_ANDI_CCR;
						m68kl0_pkg::ROW_EOR: r.op_kind = m68kl0_pkg::OP_EORI_CCR;
						default:             r.op_kind = m68kl0_pkg::OP_INVALID;
					endcase
				end else if (szf == m68kl0_pkg::SZF_WORD) begin
					unique case (row)
						m68kl0_pkg::ROW_OR:  r.op_kind = m68kl0_pkg::OP_ORI_SR;
						m68kl0_pkg::ROW_AND: r.op_kind = m68kl0_pkg::OP_ANDI_SR;
						m68kl0_pkg::ROW_EOR: r.op_kind = m68kl0_pkg::OP_EORI_SR;
						default:             r.op_kind = m68kl0_pkg::OP_INVALID;
					endcase
					r.privileged = 1'b1;
				end
			end else if (szf != m68kl0_pkg::SZF_EXTRA) begin
				// immediate ops and MOVES
				r.op_kind = m68kl0_pkg::imm_kind_of_row(row);
				unique case (szf)
					m68kl0_pkg::SZF_BYTE: r.size_bytes = m68kl0_pkg::SIZE_BYTE;
					m68kl0_pkg::SZF_WORD: r.size_bytes = m68kl0_pkg::SIZE_WORD;
					m68kl0_pkg::SZF_LONG: r.size_bytes = m68kl0_pkg::SIZE_LONG;
					default:              r.size_bytes = m68kl0_pkg::SIZE_NONE;
				endcase
				r.privileged = (row == m68kl0_pkg::ROW_MOVES);
				uses_ea      = 1'b1;
			end else begin
				// size field three: CMP2/CHK2/CAS space, not decoded
				r.op_kind = m68kl0_pkg::OP_INVALID;
			end

			if (uses_ea) begin
				r.ea_class = eac;
				r.ea_reg   = rg;
				if (eac == m68kl0_pkg::EA_NONE) begin
					r.op_kind = m68kl0_pkg::OP_INVALID;
				end
			end
		end

		// an invalid result carries all-zero fields
		if (r.op_kind == m68kl0_pkg::OP_INVALID) begin
			r = '0;
		end
		res = r;
	end

endmodule

// File: rtl/m68k_line0_instruction_decoder.sv
// Top level of the 68030 line-0 opcode decoder: input and result registers.
// Depends on m68kl0_pkg and m68kl0_decode.

// One opcode word is taken on every cycle in which start is high (busy is
// always low). The word is held in the input register, decoded in one pass
// and loaded into the result register at the next edge, so done is high for
// exactly one cycle per word, in step with the new result. The receiver
// cannot stall, so a result is never held. Throughput is one word per cycle,
// set by the single decode stage between the input register and the result
// register. There is no control state beyond the pipeline valid bits.
module m68k_line0_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] opcode_word,
	output logic        done,
	output logic [4:0]  op_kind,
	output logic [2:0]  data_reg,
	output logic [2:0]  addr_reg,
	output logic        to_memory,
	output logic [2:0]  size_bytes,
	output logic        bit_number_in_reg,
	output logic [3:0]  ea_class,
	output logic [2:0]  ea_reg,
	output logic        privileged
);

	logic                     valid_s1, valid_s2;
	logic [15:0]              word_s1;
	m68kl0_pkg::dec_result_t  dec;
	m68kl0_pkg::dec_result_t  res_s2;

	assign busy = 1'b0;

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			word_s1 <= opcode_word;
		end
	end

	m68kl0_decode u_decode (
		.word (word_s1),
		.res  (dec)
	);

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= dec;
		end
	end

	assign done              = valid_s2;
	assign op_kind           = res_s2.op_kind;
	assign data_reg          = res_s2.data_reg;
	assign addr_reg          = res_s2.addr_reg;
	assign to_memory         = res_s2.to_memory;
	assign size_bytes        = res_s2.size_bytes;
	assign bit_number_in_reg = res_s2.bit_number_in_reg;
	assign ea_class          = res_s2.ea_class;
	assign ea_reg            = res_s2.ea_reg;
	assign privileged        = res_s2.privileged;

endmodule
